### rtl/core/escape_time_fractal_iteration_top_macros.svh
// Assertion shorthands for the fractal iteration block.
// Both expect i_clk in the scope where they are used; ETFI_ASSERT also expects i_rst_n.
`ifndef ESCAPE_TIME_FRACTAL_ITERATION_TOP_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_ITERATION_TOP_MACROS_SVH

// Checked only while out of reset.
`define ETFI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ETFI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/core/etfi_pkg.sv
package etfi_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int COUNT_WIDTH     = 16;
    localparam int FRAC_BITS       = COORD_WIDTH - 4;
    localparam int PROD_WIDTH      = 2 * COORD_WIDTH;
    localparam int WIDE_WIDTH      = COORD_WIDTH + 4;
    localparam int MODE_WIDTH      = 4;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = COUNT_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef logic signed [WIDE_WIDTH-1:0]  t_wide;
    typedef logic [COUNT_WIDTH-1:0]        t_count;

    localparam t_coord COORD_MAX    = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN    = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    // 4.0 in the coordinate format
    localparam t_coord ESCAPE_BOUND = {2'b01, {(COORD_WIDTH-2){1'b0}}};

    localparam t_count             MAX_ITER_RESET = t_count'(256);
    localparam logic [MODE_WIDTH-1:0] MODE_RESET  = MODE_WIDTH'(1);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MAX_ITERATIONS = 1'b0,
        CFG_FRACTAL_MODE   = 1'b1
    } t_cfg_index;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_Z2    = 4'd1,
        MODE_Z3    = 4'd2,
        MODE_Z4    = 4'd3,
        MODE_SHIP  = 4'd4,
        MODE_ARROW = 4'd5,
        MODE_CROSS = 4'd6
    } t_mode;

    typedef enum logic [4:0] {
        U_IDLE,
        U_MXX,
        U_MYY,
        U_MXY,
        U_WXY,
        U_PREP,
        U_PREP_SHIP,
        U_T3,
        U_D3,
        U_MXS,
        U_MYQ,
        U_WM,
        U_MXXXX,
        U_MXXYY,
        U_MYYYY,
        U_MXYA,
        U_WM_SUB,
        U_ACC,
        U_FIN_AB,
        U_FIN_RM,
        U_FIN_RB,
        U_FIN_AM
    } t_uop;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MXX,
        S_MYY,
        S_MXY,
        S_WXY,
        S_PREP,
        S_T3,
        S_D3,
        S_MXS,
        S_MYQ,
        S_WM,
        S_MXXXX,
        S_MXXYY,
        S_MYYYY,
        S_MXYA,
        S_WM_SUB,
        S_ACC,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        t_uop uop;
    } t_dp_cmd;

    typedef struct packed {
        logic escape;
    } t_dp_status;

    function automatic t_coord sat_wide(input t_wide v);
        if (v > t_wide'(COORD_MAX)) begin
            return COORD_MAX;
        end else if (v < t_wide'(COORD_MIN)) begin
            return COORD_MIN;
        end
        return t_coord'(v[COORD_WIDTH-1:0]);
    endfunction

    function automatic t_coord sadd(input t_coord a, input t_coord b);
        return sat_wide(t_wide'(a) + t_wide'(b));
    endfunction

    function automatic t_coord ssub(input t_coord a, input t_coord b);
        return sat_wide(t_wide'(a) - t_wide'(b));
    endfunction

    function automatic t_coord sat_x2(input t_coord a);
        return sat_wide(t_wide'(a) <<< 1);
    endfunction

    function automatic t_coord sat_x3(input t_coord a);
        return sat_wide((t_wide'(a) <<< 1) + t_wide'(a));
    endfunction

    function automatic t_coord sat_x4(input t_coord a);
        return sat_wide(t_wide'(a) <<< 2);
    endfunction

    function automatic t_coord sat_x6(input t_coord a);
        return sat_wide((t_wide'(a) <<< 2) + (t_wide'(a) <<< 1));
    endfunction

    function automatic t_coord sabs(input t_coord a);
        if (a == COORD_MIN) begin
            return COORD_MAX;
        end else if (a < 0) begin
            return -a;
        end
        return a;
    endfunction

    // Floor of the exact product, then clamp to the coordinate range.
    function automatic t_coord sat_mul(input t_prod p);
        t_prod v;
        v = p >>> FRAC_BITS;
        if (v > t_prod'(COORD_MAX)) begin
            return COORD_MAX;
        end else if (v < t_prod'(COORD_MIN)) begin
            return COORD_MIN;
        end
        return t_coord'(v[COORD_WIDTH-1:0]);
    endfunction

endpackage

### rtl/core/etfi_point_if.sv
interface etfi_point_if;
    logic                  valid;
    logic                  ready;
    etfi_pkg::t_coord      c_real;
    etfi_pkg::t_coord      c_imag;
    etfi_pkg::t_coord      z_real_start;
    etfi_pkg::t_coord      z_imag_start;

    modport source (
        output valid, c_real, c_imag, z_real_start, z_imag_start,
        input  ready
    );
    modport sink (
        input  valid, c_real, c_imag, z_real_start, z_imag_start,
        output ready
    );
endinterface

### rtl/core/etfi_count_if.sv
interface etfi_count_if;
    logic                  valid;
    logic                  ready;
    etfi_pkg::t_count      iteration_count;

    modport source (
        output valid, iteration_count,
        input  ready
    );
    modport sink (
        input  valid, iteration_count,
        output ready
    );
endinterface

### rtl/core/etfi_cfg_if.sv
interface etfi_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [etfi_pkg::CFG_INDEX_WIDTH-1:0]   index;
    logic [etfi_pkg::CFG_DATA_WIDTH-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### rtl/core/escape_time_fractal_iteration_top.sv
// Escape-time iteration for one point: z = f(z) + c in signed Q4.28, counting
// iterations until |z|^2 >= 4 or max_iterations is reached. One shared 32x32
// multiplier takes one product per cycle. Each iteration forms x*x, y*y and x*y,
// checks for escape and prepares the terms; z^3 and z^4, arrow and cross then form
// further products before the final update adds c. One point is worked
// on at a time; the next request is taken while the previous count still waits
// in the output register. The user must write registers through the configuration
// port only while the block is idle; the block itself does not enforce this.
module escape_time_fractal_iteration_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    etfi_point_if.sink   i_point,
    etfi_count_if.source o_result,
    etfi_cfg_if.sink     i_cfg
);

    etfi_pkg::t_dp_cmd    w_cmd;
    etfi_pkg::t_dp_status w_status;

    etfi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_point  (i_point),
        .o_result (o_result),
        .i_cfg    (i_cfg),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    etfi_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_c_real       (i_point.c_real),
        .i_c_imag       (i_point.c_imag),
        .i_z_real_start (i_point.z_real_start),
        .i_z_imag_start (i_point.z_imag_start),
        .o_status       (w_status)
    );

endmodule

### rtl/core/etfi_ctrl.sv
`include "escape_time_fractal_iteration_top_macros.svh"

module etfi_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    etfi_point_if.sink           i_point,
    etfi_count_if.source         o_result,
    etfi_cfg_if.sink             i_cfg,
    output etfi_pkg::t_dp_cmd    o_cmd,
    input  etfi_pkg::t_dp_status i_status
);

    etfi_pkg::t_state                  r_state, n_state;
    etfi_pkg::t_count                  r_max_iter;
    logic [etfi_pkg::MODE_WIDTH-1:0]   r_mode;
    etfi_pkg::t_count                  r_iter;
    logic                              r_out_valid;
    etfi_pkg::t_count                  r_count_out;

    etfi_pkg::t_count                  w_iter_next;
    logic                              w_accept;
    logic                              w_out_load;
    logic                              w_more;

    assign i_cfg.ready              = 1'b1;
    assign i_point.ready            = (r_state == etfi_pkg::S_IDLE);
    assign o_result.valid           = r_out_valid;
    assign o_result.iteration_count = r_count_out;

    assign w_accept    = i_point.valid && i_point.ready;
    assign w_iter_next = r_iter + 1'b1;
    assign w_more      = (w_iter_next < r_max_iter);
    assign w_out_load  = (r_state == etfi_pkg::S_DONE) && (!r_out_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= etfi_pkg::MAX_ITER_RESET;
            r_mode     <= etfi_pkg::MODE_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (etfi_pkg::t_cfg_index'(i_cfg.index))
                etfi_pkg::CFG_MAX_ITERATIONS: begin
                    r_max_iter <= i_cfg.data[etfi_pkg::COUNT_WIDTH-1:0];
                end
                etfi_pkg::CFG_FRACTAL_MODE: begin
                    r_mode <= i_cfg.data[etfi_pkg::MODE_WIDTH-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= etfi_pkg::S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_iter <= '0;
            end else if (r_state == etfi_pkg::S_FIN) begin
                r_iter <= w_iter_next;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_count_out <= r_iter;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.uop  = etfi_pkg::U_IDLE;
        unique case (r_state)
            etfi_pkg::S_IDLE: begin
                if (i_point.valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (r_max_iter == '0) ? etfi_pkg::S_DONE : etfi_pkg::S_MXX;
                end
            end
            etfi_pkg::S_MXX: begin
                o_cmd.uop = etfi_pkg::U_MXX;
                n_state   = etfi_pkg::S_MYY;
            end
            etfi_pkg::S_MYY: begin
                o_cmd.uop = etfi_pkg::U_MYY;
                n_state   = etfi_pkg::S_MXY;
            end
            etfi_pkg::S_MXY: begin
                o_cmd.uop = etfi_pkg::U_MXY;
                n_state   = etfi_pkg::S_WXY;
            end
            etfi_pkg::S_WXY: begin
                // squares are in place here: drop out on escape
                o_cmd.uop = etfi_pkg::U_WXY;
                n_state   = i_status.escape ? etfi_pkg::S_DONE : etfi_pkg::S_PREP;
            end
            etfi_pkg::S_PREP: begin
                o_cmd.uop = (r_mode == etfi_pkg::MODE_SHIP) ? etfi_pkg::U_PREP_SHIP
                                                            : etfi_pkg::U_PREP;
                unique case (r_mode)
                    etfi_pkg::MODE_Z3: begin
                        n_state = etfi_pkg::S_T3;
                    end
                    etfi_pkg::MODE_Z4, etfi_pkg::MODE_ARROW, etfi_pkg::MODE_CROSS: begin
                        n_state = etfi_pkg::S_MXXXX;
                    end
                    default: begin
                        n_state = etfi_pkg::S_FIN;
                    end
                endcase
            end
            etfi_pkg::S_T3: begin
                o_cmd.uop = etfi_pkg::U_T3;
                n_state   = etfi_pkg::S_D3;
            end
            etfi_pkg::S_D3: begin
                o_cmd.uop = etfi_pkg::U_D3;
                n_state   = etfi_pkg::S_MXS;
            end
            etfi_pkg::S_MXS: begin
                o_cmd.uop = etfi_pkg::U_MXS;
                n_state   = etfi_pkg::S_MYQ;
            end
            etfi_pkg::S_MYQ: begin
                o_cmd.uop = etfi_pkg::U_MYQ;
                n_state   = etfi_pkg::S_WM;
            end
            etfi_pkg::S_WM: begin
                o_cmd.uop = etfi_pkg::U_WM;
                n_state   = etfi_pkg::S_FIN;
            end
            etfi_pkg::S_MXXXX: begin
                o_cmd.uop = etfi_pkg::U_MXXXX;
                n_state   = etfi_pkg::S_MXXYY;
            end
            etfi_pkg::S_MXXYY: begin
                o_cmd.uop = etfi_pkg::U_MXXYY;
                n_state   = etfi_pkg::S_MYYYY;
            end
            etfi_pkg::S_MYYYY: begin
                o_cmd.uop = etfi_pkg::U_MYYYY;
                n_state   = etfi_pkg::S_MXYA;
            end
            etfi_pkg::S_MXYA: begin
                o_cmd.uop = etfi_pkg::U_MXYA;
                n_state   = etfi_pkg::S_WM_SUB;
            end
            etfi_pkg::S_WM_SUB: begin
                o_cmd.uop = etfi_pkg::U_WM_SUB;
                n_state   = etfi_pkg::S_ACC;
            end
            etfi_pkg::S_ACC: begin
                o_cmd.uop = etfi_pkg::U_ACC;
                n_state   = etfi_pkg::S_FIN;
            end
            etfi_pkg::S_FIN: begin
                unique case (r_mode)
                    etfi_pkg::MODE_Z3, etfi_pkg::MODE_Z4: begin
                        o_cmd.uop = etfi_pkg::U_FIN_RM;
                    end
                    etfi_pkg::MODE_ARROW: begin
                        o_cmd.uop = etfi_pkg::U_FIN_RB;
                    end
                    etfi_pkg::MODE_CROSS: begin
                        o_cmd.uop = etfi_pkg::U_FIN_AM;
                    end
                    default: begin
                        o_cmd.uop = etfi_pkg::U_FIN_AB;
                    end
                endcase
                n_state = w_more ? etfi_pkg::S_MXX : etfi_pkg::S_DONE;
            end
            etfi_pkg::S_DONE: begin
                // hold until the output register is free
                if (w_out_load) begin
                    n_state = etfi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = etfi_pkg::S_IDLE;
            end
        endcase
    end

    `ETFI_ASSERT(a_iter_below_limit, (r_state != etfi_pkg::S_IDLE && r_state != etfi_pkg::S_DONE) |-> (r_iter < r_max_iter), "iteration count reached the limit inside an iteration")
    `ETFI_ASSERT(a_accept_leaves_idle, (i_point.valid && i_point.ready) |=> (r_state != etfi_pkg::S_IDLE), "accepted request did not start work")
    `ETFI_ASSERT(a_result_from_done, $rose(r_out_valid) |-> ($past(r_state) == etfi_pkg::S_DONE), "result raised outside the done state")
    `ETFI_ASSERT(a_iter_steps_by_one, (r_state != etfi_pkg::S_IDLE && $past(r_state) != etfi_pkg::S_IDLE) |-> (r_iter == $past(r_iter) || r_iter == $past(r_iter) + 1'b1), "iteration count jumped")

endmodule

### rtl/core/etfi_dp.sv
module etfi_dp (
    input  logic                 i_clk,
    input  etfi_pkg::t_dp_cmd    i_cmd,
    input  etfi_pkg::t_coord     i_c_real,
    input  etfi_pkg::t_coord     i_c_imag,
    input  etfi_pkg::t_coord     i_z_real_start,
    input  etfi_pkg::t_coord     i_z_imag_start,
    output etfi_pkg::t_dp_status o_status
);

    etfi_pkg::t_coord r_cr, r_ci, r_x, r_y;
    etfi_pkg::t_coord r_xx, r_yy, r_xy;
    // a: xx-yy, b: 2xy, r: real accumulator, s/q/m: scratch
    etfi_pkg::t_coord r_a, r_b, r_r, r_s, r_q, r_m;
    etfi_pkg::t_prod  r_prod;

    etfi_pkg::t_coord w_mul_a, w_mul_b;
    logic             w_mul_en;
    etfi_pkg::t_coord w_prod_sat;

    assign w_prod_sat      = etfi_pkg::sat_mul(r_prod);
    assign o_status.escape = (etfi_pkg::sadd(r_xx, r_yy) >= etfi_pkg::ESCAPE_BOUND);

    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = r_x;
        w_mul_b  = r_x;
        unique case (i_cmd.uop)
            etfi_pkg::U_MXX: begin
                w_mul_a = r_x;
                w_mul_b = r_x;
            end
            etfi_pkg::U_MYY: begin
                w_mul_a = r_y;
                w_mul_b = r_y;
            end
            etfi_pkg::U_MXY: begin
                w_mul_a = r_x;
                w_mul_b = r_y;
            end
            etfi_pkg::U_MXS: begin
                w_mul_a = r_x;
                w_mul_b = r_s;
            end
            etfi_pkg::U_MYQ: begin
                w_mul_a = r_y;
                w_mul_b = r_q;
            end
            etfi_pkg::U_MXXXX: begin
                w_mul_a = r_xx;
                w_mul_b = r_xx;
            end
            etfi_pkg::U_MXXYY: begin
                w_mul_a = r_xx;
                w_mul_b = r_yy;
            end
            etfi_pkg::U_MYYYY: begin
                w_mul_a = r_yy;
                w_mul_b = r_yy;
            end
            etfi_pkg::U_MXYA: begin
                w_mul_a = r_xy;
                w_mul_b = r_a;
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= etfi_pkg::t_prod'(w_mul_a) * etfi_pkg::t_prod'(w_mul_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cr <= i_c_real;
            r_ci <= i_c_imag;
            r_x  <= i_z_real_start;
            r_y  <= i_z_imag_start;
        end
        unique case (i_cmd.uop)
            etfi_pkg::U_MYY: begin
                r_xx <= w_prod_sat;
            end
            etfi_pkg::U_MXY: begin
                r_yy <= w_prod_sat;
            end
            etfi_pkg::U_WXY: begin
                r_xy <= w_prod_sat;
            end
            etfi_pkg::U_PREP: begin
                r_a <= etfi_pkg::ssub(r_xx, r_yy);
                r_b <= etfi_pkg::sat_x2(r_xy);
            end
            etfi_pkg::U_PREP_SHIP: begin
                r_a <= etfi_pkg::ssub(r_xx, r_yy);
                r_b <= etfi_pkg::sabs(etfi_pkg::sat_x2(r_xy));
            end
            etfi_pkg::U_T3: begin
                r_s <= etfi_pkg::sat_x3(r_yy);
                r_q <= etfi_pkg::sat_x3(r_xx);
            end
            etfi_pkg::U_D3: begin
                r_s <= etfi_pkg::ssub(r_xx, r_s);
                r_q <= etfi_pkg::ssub(r_q, r_yy);
            end
            etfi_pkg::U_MYQ: begin
                r_r <= w_prod_sat;
            end
            etfi_pkg::U_WM: begin
                r_m <= w_prod_sat;
            end
            etfi_pkg::U_MXXYY: begin
                r_r <= w_prod_sat;
            end
            etfi_pkg::U_MYYYY: begin
                r_s <= w_prod_sat;
            end
            etfi_pkg::U_MXYA: begin
                r_q <= w_prod_sat;
                r_s <= etfi_pkg::sat_x6(r_s);
            end
            etfi_pkg::U_WM_SUB: begin
                r_m <= w_prod_sat;
                r_r <= etfi_pkg::ssub(r_r, r_s);
            end
            etfi_pkg::U_ACC: begin
                r_r <= etfi_pkg::sadd(r_r, r_q);
                r_m <= etfi_pkg::sat_x4(r_m);
            end
            etfi_pkg::U_FIN_AB: begin
                r_x <= etfi_pkg::sadd(r_a, r_cr);
                r_y <= etfi_pkg::sadd(r_b, r_ci);
            end
            etfi_pkg::U_FIN_RM: begin
                r_x <= etfi_pkg::sadd(r_r, r_cr);
                r_y <= etfi_pkg::sadd(r_m, r_ci);
            end
            etfi_pkg::U_FIN_RB: begin
                r_x <= etfi_pkg::sadd(r_r, r_cr);
                r_y <= etfi_pkg::sadd(r_b, r_ci);
            end
            etfi_pkg::U_FIN_AM: begin
                r_x <= etfi_pkg::sadd(r_a, r_cr);
                r_y <= etfi_pkg::sadd(r_m, r_ci);
            end
            default: begin
            end
        endcase
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import etfi_pkg::*;

    typedef logic signed [63:0] t_big;

    typedef struct {
        t_coord cr;
        t_coord ci;
        t_coord zr;
        t_coord zi;
    } t_point_req;

    typedef struct {
        t_count count;
        int     seq;
    } t_count_exp;

    localparam t_coord FX_ONE = 32'sh1000_0000;
    localparam t_coord FX_TWO = 32'sh2000_0000;
    localparam int     N_RANDOM = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    etfi_point_if pt();
    etfi_count_if res();
    etfi_cfg_if   cfg();

    escape_time_fractal_iteration_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_point  (pt),
        .o_result (res),
        .i_cfg    (cfg)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_point_req pending_points[$];
    t_count_exp expected_counts[$];
    t_count     cfg_limit = MAX_ITER_RESET;
    logic [3:0] cfg_mode  = MODE_RESET;
    t_point_req cur_point;
    bit         point_taken = 1'b0;
    bit         idle_quiet = 1'b0;
    int         point_gap = 0;
    int         count_stall = 0;
    int         sent_seq = 0;
    int         got_seq = 0;
    int         err_count = 0;

    // ---------------- fixed-point predictor ----------------

    function automatic t_coord fx_clamp(t_big v);
        if (v > t_big'(COORD_MAX)) return COORD_MAX;
        if (v < t_big'(COORD_MIN)) return COORD_MIN;
        return t_coord'(v[COORD_WIDTH-1:0]);
    endfunction

    function automatic t_coord fx_add(t_coord a, t_coord b);
        return fx_clamp(t_big'(a) + t_big'(b));
    endfunction

    function automatic t_coord fx_sub(t_coord a, t_coord b);
        return fx_clamp(t_big'(a) - t_big'(b));
    endfunction

    // a run of saturating additions of one value equals one clamp of the exact multiple
    function automatic t_coord fx_scale(t_coord a, int k);
        return fx_clamp(t_big'(a) * t_big'(k));
    endfunction

    function automatic t_coord fx_mul(t_coord a, t_coord b);
        t_big p;
        p = t_big'(a) * t_big'(b);
        return fx_clamp(p >>> FRAC_BITS);
    endfunction

    function automatic t_coord fx_abs(t_coord a);
        if (a == COORD_MIN) return COORD_MAX;
        if (a < 0) return -a;
        return a;
    endfunction

    function automatic t_count predict_escape_count(t_point_req p, t_count limit,
                                                    logic [3:0] mode);
        t_coord x, y, xx, yy, xy, re2, im2, re4, im4, nr, ni;
        int n;
        x = p.zr;
        y = p.zi;
        n = 0;
        while (n < int'(limit)) begin
            xx = fx_mul(x, x);
            yy = fx_mul(y, y);
            xy = fx_mul(x, y);
            if (fx_add(xx, yy) >= ESCAPE_BOUND) break;
            re2 = fx_add(fx_sub(xx, yy), p.cr);
            im2 = fx_add(fx_scale(xy, 2), p.ci);
            re4 = fx_add(fx_add(fx_sub(fx_mul(xx, xx), fx_scale(fx_mul(xx, yy), 6)),
                                fx_mul(yy, yy)), p.cr);
            im4 = fx_add(fx_scale(fx_mul(xy, fx_sub(xx, yy)), 4), p.ci);
            case (mode)
                MODE_Z3: begin
                    nr = fx_add(fx_mul(x, fx_sub(xx, fx_scale(yy, 3))), p.cr);
                    ni = fx_add(fx_mul(y, fx_sub(fx_scale(xx, 3), yy)), p.ci);
                end
                MODE_Z4: begin
                    nr = re4;
                    ni = im4;
                end
                MODE_SHIP: begin
                    nr = re2;
                    ni = fx_add(fx_abs(fx_scale(xy, 2)), p.ci);
                end
                MODE_ARROW: begin
                    nr = re4;
                    ni = im2;
                end
                MODE_CROSS: begin
                    nr = re2;
                    ni = im4;
                end
                default: begin
                    nr = re2;
                    ni = im2;
                end
            endcase
            x = nr;
            y = ni;
            n++;
        end
        return t_count'(n);
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_coord span(int unsigned half);
        return t_coord'(longint'($urandom_range(0, 2 * half)) - longint'(half));
    endfunction

    // magnitude of at least 2.125, so the square alone leaves the disc
    function automatic t_coord far_value();
        t_coord v;
        v = t_coord'($urandom_range(32'h2200_0000, 32'h7FFF_FFFF));
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    function automatic t_coord edge_value();
        case ($urandom_range(0, 7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return -1;
            4: return 1;
            5: return FX_TWO;
            6: return -FX_TWO;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_point_req make_point(bit quick);
        t_point_req p;
        int r;
        r = $urandom_range(0, 99);
        if (quick) begin
            // escapes at once: large limits stay cheap
            if (r < 80) begin
                p.cr = far_value();
                p.ci = span(FX_TWO);
                p.zr = '0;
                p.zi = '0;
            end else begin
                p.cr = t_coord'($urandom);
                p.ci = t_coord'($urandom);
                p.zr = far_value();
                p.zi = t_coord'($urandom);
            end
        end else if (r < 70) begin
            p.cr = span(FX_TWO);
            p.ci = span(FX_TWO);
            if ($urandom_range(0, 2) == 0) begin
                p.zr = span(FX_ONE);
                p.zi = span(FX_ONE);
            end else begin
                p.zr = '0;
                p.zi = '0;
            end
        end else if (r < 85) begin
            p.cr = t_coord'($urandom);
            p.ci = t_coord'($urandom);
            p.zr = t_coord'($urandom);
            p.zi = t_coord'($urandom);
        end else begin
            p.cr = edge_value();
            p.ci = edge_value();
            p.zr = edge_value();
            p.zi = edge_value();
        end
        return p;
    endfunction

    task automatic queue_point(t_coord cr, t_coord ci, t_coord zr, t_coord zi);
        t_point_req p;
        p.cr = cr;
        p.ci = ci;
        p.zr = zr;
        p.zi = zi;
        pending_points = {pending_points, p};
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || expected_counts.size() != 0 || pt.valid)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_index idx, t_count val);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        if (idx == CFG_MAX_ITERATIONS) cfg_limit = val;
        else cfg_mode = val[3:0];
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // upper data bits of a mode write are random and must be ignored
    task automatic configure(t_count limit, logic [3:0] mode);
        wait_drained();
        cfg_write(CFG_MAX_ITERATIONS, limit);
        cfg_write(CFG_FRACTAL_MODE, t_count'(($urandom & 32'hFFF0) | mode));
    endtask

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // ---------------- request driver ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pt.valid <= 1'b0;
        end else if (pt.valid && !point_taken) begin
            // hold the request until it is taken
        end else begin
            point_taken = 1'b0;
            if (point_gap > 0) begin
                pt.valid <= 1'b0;
                point_gap--;
            end else if (pending_points.size() != 0) begin
                cur_point = pending_points.pop_front();
                pt.c_real       <= cur_point.cr;
                pt.c_imag       <= cur_point.ci;
                pt.z_real_start <= cur_point.zr;
                pt.z_imag_start <= cur_point.zi;
                pt.valid        <= 1'b1;
                point_gap = pick_gap();
            end else begin
                pt.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else if (count_stall > 0) begin
            res.ready <= 1'b0;
            count_stall--;
        end else begin
            res.ready <= 1'b1;
            count_stall = pick_gap();
        end
    end

    // ---------------- acceptance and result check ----------------

    always @(posedge i_clk) begin
        t_count_exp e;
        if (i_rst_n) begin
            if (pt.valid && pt.ready) begin
                e.count = predict_escape_count(cur_point, cfg_limit, cfg_mode);
                e.seq   = sent_seq;
                expected_counts = {expected_counts, e};
                sent_seq++;
                point_taken = 1'b1;
            end
            if (res.valid && res.ready) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("count %0d with no request outstanding",
                                              res.iteration_count));
                end else begin
                    e = expected_counts.pop_front();
                    if (res.iteration_count !== e.count)
                        report_mismatch($sformatf("request %0d: count %0d, expected %0d",
                                                  e.seq, res.iteration_count, e.count));
                end
                got_seq++;
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        t_mode      dir_modes[$];
        logic [3:0] m;
        t_count     limit;
        bit         quick;
        int         r, n_phase, random_sent;

        pt.valid        = 1'b0;
        pt.c_real       = '0;
        pt.c_imag       = '0;
        pt.z_real_start = '0;
        pt.z_imag_start = '0;
        res.ready       = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = CFG_MAX_ITERATIONS;
        cfg.data        = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: limit 256, z^2
        queue_point('0, '0, '0, '0);
        queue_point(-FX_TWO, '0, '0, '0);
        queue_point(32'sh0400_0000, '0, '0, '0);
        queue_point(32'sh0429_0000, '0, '0, '0);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_point('0, '0, FX_TWO, '0);
        queue_point('0, '0, FX_TWO - 1, '0);
        queue_point(-FX_ONE, '0, '0, '0);
        queue_point('0, FX_ONE, '0, '0);

        // zero limit
        configure('0, MODE_Z2);
        queue_point('0, '0, '0, '0);
        queue_point(-FX_ONE, '0, FX_TWO, '0);

        // every formula, unused codes included
        dir_modes = '{MODE_Z3, MODE_Z4, MODE_SHIP, MODE_ARROW, MODE_CROSS};
        for (int i = 0; i < 8; i++) begin
            if (i < 5) m = dir_modes[i];
            else if (i == 5) m = 4'd0;
            else if (i == 6) m = 4'd7;
            else m = 4'd15;
            configure(t_count'(20), m);
            queue_point(-32'sh0800_0000, 32'sh0800_0000, '0, '0);
            queue_point(-32'sh0199_999A, 32'sh0199_999A, 32'sh0800_0000, -32'sh0800_0000);
        end

        random_sent = 0;
        n_phase = 0;
        while (random_sent < N_RANDOM) begin
            r = $urandom_range(0, 99);
            quick = 1'b0;
            if (n_phase == 0) begin
                limit = 16'hFFFF;
                quick = 1'b1;
            end else if (n_phase == 1) begin
                limit = 1;
            end else if (r < 60) begin
                limit = t_count'($urandom_range(1, 24));
            end else if (r < 80) begin
                limit = t_count'($urandom_range(25, 64));
            end else if (r < 85) begin
                limit = '0;
            end else if (r < 90) begin
                limit = 1;
            end else begin
                limit = (r < 95) ? t_count'($urandom_range(256, 65535)) : 16'hFFFF;
                quick = 1'b1;
            end
            m = (n_phase == 0) ? 4'd15 : 4'($urandom_range(0, 15));
            configure(limit, m);
            idle_quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(40, 120)) begin
                pending_points = {pending_points, make_point(quick)};
                random_sent++;
            end
            n_phase++;
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/etfi_pkg.sv
rtl/core/etfi_point_if.sv
rtl/core/etfi_count_if.sv
rtl/core/etfi_cfg_if.sv
rtl/core/etfi_ctrl.sv
rtl/core/etfi_dp.sv
rtl/core/escape_time_fractal_iteration_top.sv
tb/tb_top.sv
